@@ rtl/sphc_pkg.sv @@
// Shared types, widths and constants of the spherical-to-Cartesian converter.
package sphc_pkg;

  localparam int ANGLE_W = 32;
  localparam int XY_W    = 34;
  localparam int Z_W     = 33;
  localparam int RAD_W   = 24;
  localparam int OUT_W   = 33;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [RAD_W-1:0]       RADIUS_RESET = 24'd6371;

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } sphc_rot_t;

  typedef struct packed {
    sphc_rot_t lat;
    sphc_rot_t lon;
    logic      flip_lat;
    logic      flip_lon;
  } sphc_pair_t;

  function automatic sphc_rot_t rot_step(input sphc_rot_t r,
                                         input logic signed [Z_W-1:0] atan,
                                         input int unsigned k);
    sphc_rot_t              o;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    dx = r.y >>> k;
    dy = r.x >>> k;
    if (!r.z[Z_W-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - atan;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + atan;
    end
    return o;
  endfunction

endpackage

@@ rtl/sphc_cell.sv @@
// One rotation cell of the sine/cosine chain, for latitude and longitude together.
module sphc_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sphc_pkg::sphc_pair_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sphc_pkg::sphc_pair_t out_data
);

  localparam logic signed [sphc_pkg::Z_W-1:0] ATAN =
    signed'({1'b0, sphc_pkg::ATAN_TURN[STAGE]});

  logic                 valid;
  sphc_pkg::sphc_pair_t data;
  sphc_pkg::sphc_pair_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next          = in_data;
    data_next.lat      = sphc_pkg::rot_step(in_data.lat, ATAN, STAGE);
    data_next.lon      = sphc_pkg::rot_step(in_data.lon, ATAN, STAGE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= data_next;
    end
  end

  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("cell dropped or changed a stalled request");

endmodule

@@ rtl/sphc_scale.sv @@
// Product, radius scaling, rounding and saturation stages feeding the outputs.
module sphc_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [sphc_pkg::RAD_W-1:0]         radius,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sphc_pkg::sphc_pair_t               in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sphc_pkg::OUT_W-1:0]  pos_x,
  output logic signed [sphc_pkg::OUT_W-1:0]  pos_y,
  output logic signed [sphc_pkg::OUT_W-1:0]  pos_z
);

  localparam int XY_W  = sphc_pkg::XY_W;
  localparam int OUT_W = sphc_pkg::OUT_W;
  localparam int MW    = sphc_pkg::RAD_W + 1 + XY_W;
  localparam int RW    = MW - 22;

  logic va, vb, vc;
  logic en_a, en_b, en_c;

  logic signed [XY_W-1:0] clat, slat, clon, slon;
  logic signed [31:0]     op_clat, op_clon, op_slon;
  logic signed [63:0]     pxa, pya;
  logic signed [XY_W-1:0] sza;

  logic signed [63:0]     rx_full, ry_full;
  logic signed [XY_W-1:0] cx, cy;
  logic signed [sphc_pkg::RAD_W:0] rad;
  logic signed [MW-1:0]   mbx, mby, mbz;

  logic signed [MW-1:0]   tx, ty, tz;
  logic signed [RW-1:0]   rx, ry, rz;

  function automatic logic [OUT_W-1:0] sat(input logic signed [RW-1:0] v);
    logic fits;
    fits = (v[RW-1:OUT_W-1] == '0) || (v[RW-1:OUT_W-1] == '1);
    if (fits) begin
      return v[OUT_W-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  assign en_c     = !vc || out_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;
  assign out_valid = vc;

  always_comb begin
    clat    = in_data.flip_lat ? -in_data.lat.x : in_data.lat.x;
    slat    = in_data.flip_lat ? -in_data.lat.y : in_data.lat.y;
    clon    = in_data.flip_lon ? -in_data.lon.x : in_data.lon.x;
    slon    = in_data.flip_lon ? -in_data.lon.y : in_data.lon.y;
    op_clat = clat[31:0];
    op_clon = clon[31:0];
    op_slon = slon[31:0];

    rx_full = (pxa + 64'sd536870912) >>> 30;
    ry_full = (pya + 64'sd536870912) >>> 30;
    cx      = rx_full[XY_W-1:0];
    cy      = ry_full[XY_W-1:0];
    rad     = signed'({1'b0, radius});

    tx = (mbx + MW'(64'sd2097152)) >>> 22;
    ty = (mby + MW'(64'sd2097152)) >>> 22;
    tz = (mbz + MW'(64'sd2097152)) >>> 22;
    rx = tx[RW-1:0];
    ry = ty[RW-1:0];
    rz = tz[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (en_a) begin
        va <= in_valid;
      end
      if (en_b) begin
        vb <= va;
      end
      if (en_c) begin
        vc <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pxa <= op_clat * op_clon;
      pya <= op_clat * op_slon;
      sza <= slat;
    end
    if (en_b) begin
      mbx <= MW'(rad) * MW'(cx);
      mby <= MW'(rad) * MW'(cy);
      mbz <= MW'(rad) * MW'(sza);
    end
    if (en_c) begin
      pos_x <= sat(rx);
      pos_y <= sat(ry);
      pos_z <= sat(rz);
    end
  end

endmodule

@@ rtl/spherical_to_cartesian.sv @@
// Top level: latitude/longitude to Cartesian x, y, z on a sphere of set radius.
// Accepts one latitude/longitude request per cycle while the output side is
// ready and returns one x/y/z result per request, in order. Each rotation cell
// of the sine/cosine chain is a register stage, followed by stages for the
// cosine product, the radius multiply and rounding with saturation.
// A stall on the output holds the pipeline; empty slots still fill, so input is
// refused only when every stage is occupied. Radius writes take effect at once
// and belong in idle periods.
module spherical_to_cartesian #(
  parameter int ROTATION_STAGES = 24,
  parameter int ANGLE_BITS      = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sphc_pkg::RAD_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sphc_pkg::ANGLE_W-1:0] latitude,
  input  logic signed [sphc_pkg::ANGLE_W-1:0] longitude,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sphc_pkg::OUT_W-1:0] pos_x,
  output logic signed [sphc_pkg::OUT_W-1:0] pos_y,
  output logic signed [sphc_pkg::OUT_W-1:0] pos_z
);

  localparam int ANGLE_W = sphc_pkg::ANGLE_W;
  localparam int DROP    = ANGLE_W - ANGLE_BITS;
  localparam logic [ANGLE_W-1:0] KEEP = ~((32'd1 << DROP) - 32'd1);

  logic [sphc_pkg::RAD_W-1:0] radius;

  logic                 chain_valid [ROTATION_STAGES+1];
  logic                 chain_ready [ROTATION_STAGES+1];
  sphc_pkg::sphc_pair_t chain_data  [ROTATION_STAGES+1];

  logic [ANGLE_W-1:0] lat_a, lon_a;
  logic               flip_lat, flip_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= sphc_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  always_comb begin
    lat_a    = latitude & KEEP;
    lon_a    = longitude & KEEP;
    flip_lat = lat_a[ANGLE_W-1] ^ lat_a[ANGLE_W-2];
    flip_lon = lon_a[ANGLE_W-1] ^ lon_a[ANGLE_W-2];
    lat_a[ANGLE_W-1] = lat_a[ANGLE_W-1] ^ flip_lat;
    lon_a[ANGLE_W-1] = lon_a[ANGLE_W-1] ^ flip_lon;

    chain_data[0].lat.x    = sphc_pkg::GAIN_Q30;
    chain_data[0].lat.y    = '0;
    chain_data[0].lat.z    = sphc_pkg::Z_W'(signed'(lat_a));
    chain_data[0].lon.x    = sphc_pkg::GAIN_Q30;
    chain_data[0].lon.y    = '0;
    chain_data[0].lon.z    = sphc_pkg::Z_W'(signed'(lon_a));
    chain_data[0].flip_lat = flip_lat;
    chain_data[0].flip_lon = flip_lon;
  end

  assign chain_valid[0] = in_valid;
  assign in_ready       = chain_ready[0];

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    sphc_cell #(
      .STAGE(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[i]),
      .in_ready (chain_ready[i]),
      .in_data  (chain_data[i]),
      .out_valid(chain_valid[i+1]),
      .out_ready(chain_ready[i+1]),
      .out_data (chain_data[i+1])
    );
  end

  sphc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .radius   (radius),
    .in_valid (chain_valid[ROTATION_STAGES]),
    .in_ready (chain_ready[ROTATION_STAGES]),
    .in_data  (chain_data[ROTATION_STAGES]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z)
  );

  a_drain_opens_input: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while the output side drains");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule
